[sv/urc_pkg.sv]
// Shared types, widths and constants for the ultrasonic range controller.
// Used by every module of the block; depends on nothing.
`default_nettype none

package urc_pkg;

    // Width of the elapsed microsecond counter.
    localparam int COUNT_WIDTH = 20;

    // Register widths.
    localparam int RT_W   = 8;
    localparam int MAX_W  = 10;
    localparam int OVH_W  = 12;
    localparam int TRIG_W = 8;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;

    // Derived widths.
    localparam int LIMIT_W   = RT_W + MAX_W;
    localparam int CMP_W     = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam int DIV_CNT_W = $clog2(COUNT_WIDTH + 1);

    // Stream widths.
    localparam int S_TDATA_W  = 8;
    localparam int OUT_BITS_W = 4 + MAX_W;
    localparam int M_TDATA_W  = 16;
    localparam int M_PAD_W    = M_TDATA_W - OUT_BITS_W;

    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

    // Register reset values.
    localparam logic [RT_W-1:0]   RT_RESET        = 8'd57;
    localparam logic [MAX_W-1:0]  MAX_RESET       = 10'd200;
    localparam logic [OVH_W-1:0]  OVH_RESET       = 12'd450;
    localparam logic [TRIG_W-1:0] TRIG_START_RESET = 8'd4;
    localparam logic [TRIG_W-1:0] TRIG_END_RESET   = 8'd14;

    // Register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROUNDTRIP  = 3'd0,
        REG_DIST_LIMIT = 3'd1,
        REG_OVERHEAD   = 3'd2,
        REG_TRIG_START = 3'd3,
        REG_TRIG_END   = 3'd4
    } cfg_index_t;

    // Measurement phase.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2
    } phase_t;

    // Item sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DECIDE,
        ST_DIV,
        ST_PUSH
    } fsm_state_t;

    // Current register contents.
    typedef struct packed {
        logic [RT_W-1:0]   roundtrip;
        logic [MAX_W-1:0]  dist_limit;
        logic [OVH_W-1:0]  overhead;
        logic [TRIG_W-1:0] trig_start;
        logic [TRIG_W-1:0] trig_end;
    } cfg_t;

    // Divider request and response.
    typedef struct packed {
        logic                   start;
        logic [COUNT_WIDTH-1:0] dividend;
        logic [RT_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [COUNT_WIDTH-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

[sv/urc_cfg.sv]
// Configuration register file of the ultrasonic range controller.
// Depends on urc_pkg for register indexes, widths and reset values.
`default_nettype none

module urc_cfg
    import urc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode a write into the addressed register; unused indexes are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index_t'(cfg_addr))
                REG_ROUNDTRIP:  cfg_next.roundtrip  = cfg_wdata[RT_W-1:0];
                REG_DIST_LIMIT: cfg_next.dist_limit = cfg_wdata[MAX_W-1:0];
                REG_OVERHEAD:   cfg_next.overhead   = cfg_wdata[OVH_W-1:0];
                REG_TRIG_START: cfg_next.trig_start = cfg_wdata[TRIG_W-1:0];
                REG_TRIG_END:   cfg_next.trig_end   = cfg_wdata[TRIG_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.roundtrip  <= RT_RESET;
            cfg_reg.dist_limit <= MAX_RESET;
            cfg_reg.overhead   <= OVH_RESET;
            cfg_reg.trig_start <= TRIG_START_RESET;
            cfg_reg.trig_end   <= TRIG_END_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[sv/urc_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on urc_pkg for the counter width and request/response types.
`default_nettype none

module urc_div
    import urc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  div_req_t  req,
    output div_rsp_t  rsp
);

    logic [RT_W-1:0]        rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0] quo_reg, quo_next;
    logic [RT_W-1:0]        den_reg, den_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [RT_W:0] trial;
    logic [RT_W:0] diff;
    logic          fits;

    // One step: bring down the next dividend bit and try a subtraction.
    assign trial = {rem_reg, quo_reg[COUNT_WIDTH-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
            cnt_next  = DIV_CNT_W'(COUNT_WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[RT_W-1:0] : trial[RT_W-1:0];
            quo_next = {quo_reg[COUNT_WIDTH-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

[sv/ultrasonic_range_controller_core.sv]
// Ultrasonic echo ranging controller: one result item per microsecond tick item.
// An accepted item passes the evaluate, decide and push states into the result register;
// an echo edge that needs a distance also waits in the serial divider.
// A new item is accepted only once the previous result item has been pushed.
// Reset (aresetn low, synchronous): idle phase, counter and last distance zero,
// registers at their default values, no result pending.
`default_nettype none

module ultrasonic_range_controller_core
    import urc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input item: [0] start_request, [1] echo_level, [7:2] zero.
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // Result item: [0] trigger_level, [1] busy_flag, [2] result_valid,
    // [3] timed_out, [13:4] distance_cm, [15:14] zero.
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    fsm_state_t st_reg, st_next;

    // Captured input item.
    logic in_start_reg, in_start_next;
    logic in_echo_reg, in_echo_next;

    // Measurement state.
    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic                   echo_prev_reg, echo_prev_next;
    logic [MAX_W-1:0]       last_dist_reg, last_dist_next;

    // Values prepared for the decision step.
    phase_t                 ev_phase_reg, ev_phase_next;
    logic [COUNT_WIDTH-1:0] ev_elapsed_reg, ev_elapsed_next;
    logic                   ev_rising_reg, ev_rising_next;
    logic [LIMIT_W-1:0]     limit_reg, limit_next;

    // Pending result flags.
    logic res_trig_reg, res_trig_next;
    logic res_valid_reg, res_valid_next;
    logic res_tmo_reg, res_tmo_next;

    // Output register.
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    phase_t                 ph_cur;
    phase_t                 ph_new;
    logic [CMP_W-1:0]       e_ext;
    logic [CMP_W-1:0]       limit_ext;
    logic                   trig_now;
    logic                   busy_now;
    logic [COUNT_WIDTH-1:0] quot;

    urc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    urc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // An unknown phase code behaves as idle.
    assign ph_cur    = (phase_reg == PH_TRIG || phase_reg == PH_WAIT) ? phase_reg : PH_IDLE;
    assign e_ext     = CMP_W'(ev_elapsed_reg);
    assign limit_ext = CMP_W'(limit_reg);
    assign trig_now  = (ev_phase_reg == PH_TRIG)
                    && (ev_elapsed_reg >= COUNT_WIDTH'(cfg.trig_start))
                    && (ev_elapsed_reg <  COUNT_WIDTH'(cfg.trig_end));
    assign busy_now  = (phase_reg != PH_IDLE);
    assign quot      = div_rsp.quotient;

    // Sequencer: next state, state updates and handshakes.
    always_comb begin
        st_next         = st_reg;
        in_start_next   = in_start_reg;
        in_echo_next    = in_echo_reg;
        phase_next      = phase_reg;
        elapsed_next    = elapsed_reg;
        echo_prev_next  = echo_prev_reg;
        last_dist_next  = last_dist_reg;
        ev_phase_next   = ev_phase_reg;
        ev_elapsed_next = ev_elapsed_reg;
        ev_rising_next  = ev_rising_reg;
        limit_next      = limit_reg;
        res_trig_next   = res_trig_reg;
        res_valid_next  = res_valid_reg;
        res_tmo_next    = res_tmo_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        ph_new          = ev_phase_reg;
        s_tready        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = ev_elapsed_reg - COUNT_WIDTH'(cfg.overhead);
        div_req.divisor  = cfg.roundtrip;

        case (st_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    in_start_next = s_tdata[0];
                    in_echo_next  = s_tdata[1];
                    st_next       = ST_EVAL;
                end
            end

            // Start a measurement if asked, note the echo edge, form the timeout.
            ST_EVAL: begin
                if (ph_cur == PH_IDLE && in_start_reg) begin
                    ev_phase_next   = PH_TRIG;
                    ev_elapsed_next = '0;
                end else begin
                    ev_phase_next   = ph_cur;
                    ev_elapsed_next = elapsed_reg;
                end
                ev_rising_next = in_echo_reg && !echo_prev_reg;
                echo_prev_next = in_echo_reg;
                limit_next     = LIMIT_W'(cfg.dist_limit) * LIMIT_W'(cfg.roundtrip);
                st_next        = ST_DECIDE;
            end

            // Advance the phase and finish unless a division is needed.
            ST_DECIDE: begin
                res_trig_next  = trig_now;
                res_valid_next = 1'b0;
                res_tmo_next   = 1'b0;
                st_next        = ST_PUSH;
                case (ev_phase_reg)
                    PH_TRIG: begin
                        if (ev_elapsed_reg >= COUNT_WIDTH'(cfg.trig_end)) begin
                            ph_new = PH_WAIT;
                        end
                    end
                    PH_WAIT: begin
                        if (ev_rising_reg) begin
                            if (ev_elapsed_reg <= COUNT_WIDTH'(cfg.overhead)) begin
                                // Echo arrived before the fixed overhead ran out.
                                last_dist_next = cfg.dist_limit;
                                res_valid_next = 1'b1;
                                res_tmo_next   = 1'b1;
                                ph_new         = PH_IDLE;
                            end else if (cfg.roundtrip == '0) begin
                                last_dist_next = cfg.dist_limit;
                                res_valid_next = 1'b1;
                                ph_new         = PH_IDLE;
                            end else begin
                                div_req.start = 1'b1;
                                st_next       = ST_DIV;
                            end
                        end else if (e_ext > limit_ext || ev_elapsed_reg == COUNT_TOP) begin
                            // No echo in time.
                            last_dist_next = cfg.dist_limit;
                            res_valid_next = 1'b1;
                            res_tmo_next   = 1'b1;
                            ph_new         = PH_IDLE;
                        end
                    end
                    default: ph_new = PH_IDLE;
                endcase
                phase_next = ph_new;
                if (ph_new != PH_IDLE && ev_elapsed_reg != COUNT_TOP) begin
                    elapsed_next = ev_elapsed_reg + COUNT_WIDTH'(1);
                end else begin
                    elapsed_next = ev_elapsed_reg;
                end
            end

            // Wait for the quotient, then round up zero and clamp to the maximum.
            ST_DIV: begin
                if (div_rsp.done) begin
                    if (quot == '0 && cfg.dist_limit != '0) begin
                        last_dist_next = MAX_W'(1);
                    end else if (quot > COUNT_WIDTH'(cfg.dist_limit)) begin
                        last_dist_next = cfg.dist_limit;
                    end else begin
                        last_dist_next = quot[MAX_W-1:0];
                    end
                    res_valid_next = 1'b1;
                    res_tmo_next   = 1'b0;
                    phase_next     = PH_IDLE;
                    st_next        = ST_PUSH;
                end
            end

            // Move the result item into the output register when it is free.
            ST_PUSH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{M_PAD_W{1'b0}}, last_dist_reg, res_tmo_reg,
                                     res_valid_reg, busy_now, res_trig_reg};
                    st_next       = ST_IDLE;
                end
            end

            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            echo_prev_reg <= 1'b0;
            last_dist_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            st_reg        <= st_next;
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            echo_prev_reg <= echo_prev_next;
            last_dist_reg <= last_dist_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        in_start_reg   <= in_start_next;
        in_echo_reg    <= in_echo_next;
        ev_phase_reg   <= ev_phase_next;
        ev_elapsed_reg <= ev_elapsed_next;
        ev_rising_reg  <= ev_rising_next;
        limit_reg      <= limit_next;
        res_trig_reg   <= res_trig_next;
        res_valid_reg  <= res_valid_next;
        res_tmo_reg    <= res_tmo_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

[sv/urc_checker.sv]
// Port-level checks for the ultrasonic range controller, bound to the top level.
// Depends on urc_pkg for port widths.
`default_nettype none

module urc_checker
    import urc_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready
);

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // Timeout is only flagged on a completing tick.
    a_tmo_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> !m_tdata[3])
        else $error("timed_out without result_valid");

    // A completed measurement leaves the block idle.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tdata[1])
        else $error("busy_flag set on completion item");

    // The trigger pulse only occurs during a measurement.
    a_trig_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("trigger high while not busy");

endmodule

bind ultrasonic_range_controller_core urc_checker u_urc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
